// ===== design/dmwc_pkg.sv =====
// shared types and constants for the direct-mapped write-back cache
package dmwc_pkg;

   localparam int ADDR_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 1;
   localparam int OUT_LINE_W  = 64;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic {
      KIND_READ  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

// ===== design/direct_mapped_writeback_cache.sv =====
// Direct-mapped write-back cache over a byte memory that is held inside the block as rows of
// one line each. After reset a clearing pass zeroes every row and every cache line; no request
// is taken until it ends. A hit completes in the lookup state. A clean miss issues its backing
// read in the lookup state and completes in the refill state; a dirty miss writes the old line
// back in the lookup state and issues the read in the fetch state, before refill, as the tag/line
// store and the backing memory both give registered read data. A read result waits in an
// output register; the next request is taken while it waits, and a later read stalls only if
// the register is still full and not drained when its result is ready. Writes give no result.
module direct_mapped_writeback_cache #(
   parameter int LINES        = 64,
   parameter int LINE_BYTES   = 8,
   parameter int MEMORY_BYTES = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dmwc_pkg::REQ_TDATA_W-1:0]     req_tdata,   // address[15:0], write_data[23:16]
   input  logic [dmwc_pkg::REQ_TUSER_W-1:0]     req_tuser,   // kind[0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dmwc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // line_data[63:0], read_byte[71:64]
   output logic [dmwc_pkg::RSP_TUSER_W-1:0]     rsp_tuser    // hit[0], was_dirty[1]
);
   import dmwc_pkg::*;

   localparam int OFF_W    = $clog2(LINE_BYTES);
   localparam int IDX_W    = $clog2(LINES);
   localparam int LINE_W   = LINE_BYTES * BYTE_W;
   localparam int MEM_ROWS = MEMORY_BYTES / LINE_BYTES;
   localparam int ROW_W    = $clog2(MEM_ROWS);
   localparam int TAG_BITS = ADDR_W - OFF_W - IDX_W;
   localparam int TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
   localparam int CLR_W    = (ROW_W > IDX_W) ? ROW_W : IDX_W;
   localparam int EXT_W    = (LINE_W > OUT_LINE_W) ? LINE_W : OUT_LINE_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FETCH,
      ST_REFILL
   } state_type;

   state_type                 state_ff, state_in;
   logic [CLR_W-1:0]          clr_cnt_ff, clr_cnt_in;
   kind_type                  kind_ff, kind_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [BYTE_W-1:0]         wdata_ff, wdata_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0]    rsp_user_ff, rsp_user_in;

   logic                      accept;
   logic                      rsp_free;
   logic                      hit;
   logic [31:0]               in_line_num;
   logic [31:0]               line_num;
   logic [31:0]               tag_num;
   logic [31:0]               wb_num;
   logic [IDX_W-1:0]          in_idx;
   logic [IDX_W-1:0]          idx;
   logic [OFF_W-1:0]          off;
   logic [TAG_W-1:0]          tag;
   logic [ROW_W-1:0]          fill_row;
   logic [ROW_W-1:0]          wb_row;
   logic [LINE_W-1:0]         cur_line;
   logic [LINE_W-1:0]         merged_line;
   logic [EXT_W-1:0]          ext_line;
   logic [RSP_TDATA_W-1:0]    result_data;

   mem_ctl_type               cs_ctl;
   logic [IDX_W-1:0]          cs_addr;
   logic [TAG_W-1:0]          cs_wr_tag;
   logic                      cs_wr_dirty;
   logic [LINE_W-1:0]         cs_wr_line;
   logic [TAG_W-1:0]          cs_rd_tag;
   logic                      cs_rd_dirty;
   logic [LINE_W-1:0]         cs_rd_line;

   mem_ctl_type               bk_ctl;
   logic [ROW_W-1:0]          bk_wr_row;
   logic [LINE_W-1:0]         bk_wr_data;
   logic [ROW_W-1:0]          bk_rd_row;
   logic [LINE_W-1:0]         bk_rd_data;

   dmwc_cache_store #(
      .LINES  (LINES),
      .LINE_W (LINE_W),
      .TAG_W  (TAG_W)
   ) u_cache_store (
      .clock    (clock),
      .ctl      (cs_ctl),
      .addr     (cs_addr),
      .wr_tag   (cs_wr_tag),
      .wr_dirty (cs_wr_dirty),
      .wr_line  (cs_wr_line),
      .rd_tag   (cs_rd_tag),
      .rd_dirty (cs_rd_dirty),
      .rd_line  (cs_rd_line)
   );

   dmwc_backing_mem #(
      .ROWS   (MEM_ROWS),
      .LINE_W (LINE_W)
   ) u_backing_mem (
      .clock   (clock),
      .ctl     (bk_ctl),
      .wr_row  (bk_wr_row),
      .wr_data (bk_wr_data),
      .rd_row  (bk_rd_row),
      .rd_data (bk_rd_data)
   );

   // address split; bits past the top of the address read as zero
   assign in_line_num = 32'(req_tdata[ADDR_W-1:0]) >> OFF_W;
   assign in_idx      = in_line_num[IDX_W-1:0];
   assign line_num    = 32'(addr_ff) >> OFF_W;
   assign tag_num     = 32'(addr_ff) >> (OFF_W + IDX_W);
   assign idx         = line_num[IDX_W-1:0];
   assign off         = addr_ff[OFF_W-1:0];
   assign tag         = tag_num[TAG_W-1:0];
   // rows wrap at the end of the backing memory
   assign fill_row    = line_num[ROW_W-1:0];
   assign wb_num      = (32'(cs_rd_tag) << IDX_W) | 32'(idx);
   assign wb_row      = wb_num[ROW_W-1:0];

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign hit      = (cs_rd_tag == tag);
   assign cur_line = (state_ff == ST_REFILL) ? bk_rd_data : cs_rd_line;

   always_comb begin
      merged_line = cur_line;
      merged_line[off*BYTE_W +: BYTE_W] = wdata_ff;
   end

   assign ext_line    = EXT_W'(cur_line);
   assign result_data = {cur_line[off*BYTE_W +: BYTE_W], ext_line[OUT_LINE_W-1:0]};

   // memory control
   always_comb begin
      cs_ctl      = '0;
      cs_addr     = idx;
      cs_wr_tag   = tag;
      cs_wr_dirty = 1'b0;
      cs_wr_line  = merged_line;
      bk_ctl      = '0;
      bk_wr_row   = wb_row;
      bk_wr_data  = cs_rd_line;
      bk_rd_row   = fill_row;
      unique case (state_ff)
         ST_CLEAR: begin
            cs_ctl.wr_en = 1'b1;
            cs_addr      = clr_cnt_ff[IDX_W-1:0];
            cs_wr_tag    = '0;
            cs_wr_line   = '0;
            bk_ctl.wr_en = 1'b1;
            bk_wr_row    = clr_cnt_ff[ROW_W-1:0];
            bk_wr_data   = '0;
         end
         ST_IDLE: begin
            cs_ctl.rd_en = accept;
            cs_addr      = in_idx;
         end
         ST_LOOKUP: begin
            if (hit) begin
               cs_ctl.wr_en = (kind_ff == KIND_WRITE);
               cs_wr_dirty  = 1'b1;
            end else if (cs_rd_dirty) begin
               bk_ctl.wr_en = 1'b1;
            end else begin
               bk_ctl.rd_en = 1'b1;
            end
         end
         ST_FETCH: begin
            bk_ctl.rd_en = 1'b1;
         end
         ST_REFILL: begin
            cs_ctl.wr_en = (kind_ff == KIND_WRITE) || rsp_free;
            cs_wr_dirty  = (kind_ff == KIND_WRITE);
            cs_wr_line   = (kind_ff == KIND_WRITE) ? merged_line : bk_rd_data;
         end
         default: begin
            cs_ctl = '0;
         end
      endcase
   end

   // next state and registered outputs
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      wdata_in     = wdata_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in  = kind_type'(req_tuser[0]);
               addr_in  = req_tdata[ADDR_W-1:0];
               wdata_in = req_tdata[ADDR_W +: BYTE_W];
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (hit) begin
               if (kind_ff == KIND_WRITE) begin
                  state_in = ST_IDLE;
               end else if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = result_data;
                  rsp_user_in  = {cs_rd_dirty, 1'b1};
                  state_in     = ST_IDLE;
               end
            end else if (cs_rd_dirty) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_REFILL;
            end
         end
         ST_FETCH: begin
            state_in = ST_REFILL;
         end
         ST_REFILL: begin
            if (kind_ff == KIND_WRITE) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_data;
               rsp_user_in  = {cs_rd_dirty, 1'b0};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      addr_ff     <= addr_in;
      wdata_ff    <= wdata_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_LOOKUP))
      else $error("accepted beat not followed by lookup");

   a_backing_one_access: assert property (@(posedge clock) disable iff (reset)
      !(bk_ctl.wr_en && bk_ctl.rd_en))
      else $error("write-back and refill in the same cycle");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_LOOKUP || state_ff == ST_REFILL))
      else $error("response raised outside lookup or refill");

   a_no_beat_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!req_tready && !cs_ctl.rd_en))
      else $error("access during clearing pass");

endmodule

// ===== design/dmwc_cache_store.sv =====
// tag, dirty mark and line data arrays of the cache, one shared address
module dmwc_cache_store #(
   parameter int LINES  = 64,
   parameter int LINE_W = 64,
   parameter int TAG_W  = 7
) (
   input  logic                      clock,
   input  dmwc_pkg::mem_ctl_type     ctl,
   input  logic [$clog2(LINES)-1:0]  addr,
   input  logic [TAG_W-1:0]          wr_tag,
   input  logic                      wr_dirty,
   input  logic [LINE_W-1:0]         wr_line,
   output logic [TAG_W-1:0]          rd_tag,
   output logic                      rd_dirty,
   output logic [LINE_W-1:0]         rd_line
);
   import dmwc_pkg::*;

   logic [TAG_W:0]    tag_mem [LINES];
   logic [LINE_W-1:0] line_mem [LINES];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         tag_mem[addr]  <= {wr_dirty, wr_tag};
         line_mem[addr] <= wr_line;
      end
      if (ctl.rd_en) begin
         {rd_dirty, rd_tag} <= tag_mem[addr];
         rd_line            <= line_mem[addr];
      end
   end

endmodule

// ===== design/dmwc_backing_mem.sv =====
// backing byte memory held as line-wide rows, one write and one read port
module dmwc_backing_mem #(
   parameter int ROWS   = 8192,
   parameter int LINE_W = 64
) (
   input  logic                     clock,
   input  dmwc_pkg::mem_ctl_type    ctl,
   input  logic [$clog2(ROWS)-1:0]  wr_row,
   input  logic [LINE_W-1:0]        wr_data,
   input  logic [$clog2(ROWS)-1:0]  rd_row,
   output logic [LINE_W-1:0]        rd_data
);
   import dmwc_pkg::*;

   logic [LINE_W-1:0] row_mem [ROWS];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         row_mem[wr_row] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data <= row_mem[rd_row];
      end
   end

endmodule

// ===== bench/direct_mapped_writeback_cache_check.sv =====
// checker for the cache: predicts each read result from accepted request beats and compares
`timescale 1ns / 100ps
module direct_mapped_writeback_cache_check
   import dmwc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // address[15:0], write_data[23:16]
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // kind[0]
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // line_data[63:0], read_byte[71:64]
   input  logic [RSP_TUSER_W-1:0] rsp_tuser,   // hit[0], was_dirty[1]
   output int                     failures,
   output int                     pending,
   output int                     reads_seen,
   output int                     writes_seen,
   output int                     hits_seen,
   output int                     writebacks_seen
);

   typedef struct {
      logic [ADDR_W-1:0]     address;
      logic [OUT_LINE_W-1:0] line_data;
      logic [BYTE_W-1:0]     read_byte;
      logic                  hit;
      logic                  was_dirty;
   } read_outcome_t;

   // shadow copy of the cache and its backing memory
   logic [6:0]            line_tag   [64];
   logic                  line_dirty [64];
   logic [OUT_LINE_W-1:0] line_bytes [64];
   logic [BYTE_W-1:0]     memory_image [65536];

   read_outcome_t outcome_q[$];
   int mismatch_total, read_total, write_total, hit_total, writeback_total;

   initial begin
      for (int i = 0; i < 64; i++) begin
         line_tag[i]   = '0;
         line_dirty[i] = 1'b0;
         line_bytes[i] = '0;
      end
      for (int i = 0; i < 65536; i++) memory_image[i] = '0;
      mismatch_total  = 0;
      read_total      = 0;
      write_total     = 0;
      hit_total       = 0;
      writeback_total = 0;
      failures        = 0;
      pending         = 0;
      reads_seen      = 0;
      writes_seen     = 0;
      hits_seen       = 0;
      writebacks_seen = 0;
   end

   task automatic note_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_total++;
   endtask

   task automatic cache_access(input kind_type kind, input logic [15:0] address,
                               input logic [7:0] write_data);
      logic [5:0]    idx;
      logic [2:0]    off;
      logic [6:0]    tag;
      logic          matched;
      logic          dirty_before;
      logic [15:0]   victim;
      read_outcome_t outcome;
      idx          = address[8:3];
      off          = address[2:0];
      tag          = address[15:9];
      matched      = (line_tag[idx] == tag);
      dirty_before = line_dirty[idx];
      if (matched) hit_total++;
      if (!matched) begin
         if (line_dirty[idx]) begin
            for (int i = 0; i < 8; i++) begin
               victim = {line_tag[idx], idx, 3'(i)};
               memory_image[victim] = line_bytes[idx][8*i +: 8];
            end
            line_dirty[idx] = 1'b0;
            writeback_total++;
         end
         line_tag[idx] = tag;
         for (int i = 0; i < 8; i++)
            line_bytes[idx][8*i +: 8] = memory_image[{address[15:3], 3'(i)}];
      end
      if (kind == KIND_WRITE) begin
         line_bytes[idx][8*off +: 8] = write_data;
         line_dirty[idx] = 1'b1;
         write_total++;
      end else begin
         outcome.address   = address;
         outcome.line_data = line_bytes[idx];
         outcome.read_byte = line_bytes[idx][8*off +: 8];
         outcome.hit       = matched;
         outcome.was_dirty = dirty_before;
         outcome_q.push_back(outcome);
         read_total++;
      end
   endtask

   task automatic compare_read(input read_outcome_t want);
      string where;
      where = $sformatf("read of 0x%04h", want.address);
      if (rsp_tdata[63:0] !== want.line_data)
         note_mismatch($sformatf("%s line_data got %h want %h", where,
                                 rsp_tdata[63:0], want.line_data));
      if (rsp_tdata[71:64] !== want.read_byte)
         note_mismatch($sformatf("%s read_byte got %h want %h", where,
                                 rsp_tdata[71:64], want.read_byte));
      if (rsp_tuser[0] !== want.hit)
         note_mismatch($sformatf("%s hit got %b want %b", where, rsp_tuser[0], want.hit));
      if (rsp_tuser[1] !== want.was_dirty)
         note_mismatch($sformatf("%s was_dirty got %b want %b", where,
                                 rsp_tuser[1], want.was_dirty));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0)
               note_mismatch($sformatf("read result %h/%b with no read outstanding",
                                       rsp_tdata, rsp_tuser));
            else
               compare_read(outcome_q.pop_front());
         end
         if (req_tvalid && req_tready)
            cache_access(kind_type'(req_tuser[0]), req_tdata[15:0], req_tdata[23:16]);
      end
      failures        <= mismatch_total;
      pending         <= outcome_q.size();
      reads_seen      <= read_total;
      writes_seen     <= write_total;
      hits_seen       <= hit_total;
      writebacks_seen <= writeback_total;
   end

endmodule

// ===== bench/direct_mapped_writeback_cache_test.sv =====
// top of the cache testbench: clock, reset, access stimulus, idling and verdict
`timescale 1ns / 100ps
module direct_mapped_writeback_cache_test;
   import dmwc_pkg::*;

   localparam int RANDOM_ACCESSES = 630;
   localparam int STALL_LIMIT     = 40000;   // covers the clearing pass after reset

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // address[15:0], write_data[23:16]
   logic [REQ_TUSER_W-1:0] req_tuser = '0;   // kind[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // line_data[63:0], read_byte[71:64]
   logic [RSP_TUSER_W-1:0] rsp_tuser;        // hit[0], was_dirty[1]

   logic calm = 1'b0;   // no idling on either side while set
   int   failures, pending, reads_seen, writes_seen, hits_seen, writebacks_seen;
   int   quiet_cycles = 0;

   logic [6:0] hot_tags  [4];
   logic [5:0] hot_lines [6];

   always #10 clock = ~clock;

   direct_mapped_writeback_cache dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   direct_mapped_writeback_cache_check checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .failures        (failures),
      .pending         (pending),
      .reads_seen      (reads_seen),
      .writes_seen     (writes_seen),
      .hits_seen       (hits_seen),
      .writebacks_seen (writebacks_seen)
   );

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 26);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("no beat accepted for %0d cycles", STALL_LIMIT);
         $display("direct_mapped_writeback_cache regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_access(input kind_type kind, input logic [15:0] address,
                              input logic [7:0] write_data);
      while (!calm && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {write_data, address};
      do @(posedge clock); while (!req_tready);
   endtask

   // the outstanding count is registered, so it lags the last accepted beat
   task automatic wait_for_reads;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic pick_hot_set;
      for (int i = 0; i < 4; i++) hot_tags[i] = 7'($urandom);
      for (int i = 0; i < 6; i++) hot_lines[i] = 6'($urandom);
   endtask

   initial begin
      logic [15:0] address;
      kind_type    kind;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // tag 0 hits before anything is written, and address zero is an ordinary read
      send_access(KIND_READ,  16'h0000, 8'h00);
      send_access(KIND_READ,  16'hFFFF, 8'h00);
      send_access(KIND_WRITE, 16'hFFFF, 8'hFF);
      send_access(KIND_READ,  16'hFFFF, 8'h00);
      // conflict on the last line forces a write-back, then the old line comes back
      send_access(KIND_READ,  16'h01F8, 8'h00);
      send_access(KIND_READ,  16'hFFF8, 8'h00);
      send_access(KIND_WRITE, 16'h0000, 8'hA5);
      send_access(KIND_WRITE, 16'h0007, 8'h5A);
      send_access(KIND_WRITE, 16'h0003, 8'h00);
      send_access(KIND_READ,  16'h0000, 8'hFF);
      send_access(KIND_WRITE, 16'h0200, 8'h55);
      send_access(KIND_READ,  16'h0205, 8'h00);
      send_access(KIND_READ,  16'h0001, 8'h00);
      send_access(KIND_WRITE, 16'hAAAA, 8'hAA);
      send_access(KIND_WRITE, 16'h5555, 8'h55);
      send_access(KIND_READ,  16'hAAAA, 8'h00);
      send_access(KIND_READ,  16'h5555, 8'h00);
      send_access(KIND_READ,  16'h2AA8, 8'h00);
      send_access(KIND_READ,  16'h8000, 8'h00);

      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         if (n % 100 == 0) pick_hot_set();
         calm <= (n >= 200 && n < 320);
         if (n == 330) begin
            req_tvalid <= 1'b0;
            wait_for_reads();
         end
         // mostly a small set of tags and lines so hits and evictions are common
         if ($urandom_range(99) < 70)
            address = {hot_tags[$urandom_range(3)], hot_lines[$urandom_range(5)],
                       3'($urandom)};
         else
            address = 16'($urandom);
         kind = kind_type'($urandom_range(1));
         send_access(kind, address, 8'($urandom));
      end
      req_tvalid <= 1'b0;
      calm       <= 1'b0;

      wait_for_reads();
      repeat (30) @(posedge clock);

      $display("covered %0d reads and %0d writes: %0d hits, %0d dirty write-backs",
               reads_seen, writes_seen, hits_seen, writebacks_seen);
      $display("%0d mismatches, %0d reads outstanding", failures, pending);
      if (failures == 0 && pending == 0)
         $display("direct_mapped_writeback_cache regression: pass");
      else
         $display("direct_mapped_writeback_cache regression: fail");
      $finish;
   end

endmodule
